FILE: hw/rtl/pvtd_pkg.sv
package pvtd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned SCALE_W  = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned GROUP_W  = 7;
	localparam int unsigned GIDX_W   = 3;

	localparam logic [GIDX_W-1:0] MAX_GROUPS = 3'd5;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd1;

	localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TERM  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] table_byte;
		logic              final_byte;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   pc_start;
		logic [WORD_W-1:0]   pc_end;
		logic [WORD_W-1:0]   entry_value;
		logic                last;
	} result_t;

endpackage

FILE: hw/rtl/pvtd_in_stage.sv
module pvtd_in_stage
	import pvtd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     advance,
	output logic     fire,
	output in_item_t item_s1
);

	logic valid_s1;

	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: hw/rtl/pvtd_core.sv
module pvtd_core
	import pvtd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [SCALE_W-1:0] cfg_wr_data,
	input  logic               fire,
	input  in_item_t           item,
	output logic               res_valid,
	output result_t            res
);

	logic [SCALE_W-1:0] pc_scale_q;
	logic [WORD_W-1:0]  varint_acc_q, varint_acc_d;
	logic [GIDX_W-1:0]  group_index_q, group_index_d;
	logic               in_pc_delta_q, in_pc_delta_d;
	logic               first_pair_q, first_pair_d;
	logic               finished_q, finished_d;
	logic [WORD_W-1:0]  running_value_q, running_value_d;
	logic [WORD_W-1:0]  range_start_q, range_start_d;

	logic [GROUP_W-1:0] grp;
	logic [WORD_W-1:0]  grp_shifted;
	logic [WORD_W-1:0]  acc_new;
	logic [WORD_W-1:0]  zig;
	logic [WORD_W-1:0]  value_new;
	logic [WORD_W-1:0]  pc_step;
	logic [WORD_W-1:0]  pc_end;
	logic               clear;

	assign grp = item.table_byte[GROUP_W-1:0];

	// place the group; bits past the word are dropped
	always_comb begin
		unique case (group_index_q)
			3'd0:    grp_shifted = {25'b0, grp};
			3'd1:    grp_shifted = {18'b0, grp, 7'b0};
			3'd2:    grp_shifted = {11'b0, grp, 14'b0};
			3'd3:    grp_shifted = {4'b0, grp, 21'b0};
			3'd4:    grp_shifted = {grp[3:0], 28'b0};
			default: grp_shifted = '0;
		endcase
	end

	assign acc_new   = varint_acc_q | grp_shifted;
	assign zig       = {1'b0, acc_new[WORD_W-1:1]} ^ {WORD_W{acc_new[0]}};
	assign value_new = running_value_q + zig;
	assign pc_step   = acc_new * {{(WORD_W-SCALE_W){1'b0}}, pc_scale_q};
	assign pc_end    = range_start_q + pc_step;

	always_comb begin
		varint_acc_d    = varint_acc_q;
		group_index_d   = group_index_q;
		in_pc_delta_d   = in_pc_delta_q;
		first_pair_d    = first_pair_q;
		finished_d      = finished_q;
		running_value_d = running_value_q;
		range_start_d   = range_start_q;
		clear           = 1'b0;
		res_valid       = 1'b0;
		res.status      = ST_TRUNC;
		res.pc_start    = range_start_q;
		res.pc_end      = range_start_q;
		res.entry_value = running_value_q;
		res.last        = 1'b1;

		if (fire) begin
			if (finished_q) begin
				// skip the rest of the table after a terminator
				clear = item.final_byte;
			end else if (item.table_byte[BYTE_W-1]) begin
				varint_acc_d = acc_new;
				if (group_index_q < MAX_GROUPS) begin
					group_index_d = group_index_q + 3'd1;
				end
				if (item.final_byte) begin
					res_valid = 1'b1;
					clear     = 1'b1;
				end
			end else begin
				varint_acc_d  = '0;
				group_index_d = '0;
				if (!in_pc_delta_q) begin
					if (acc_new == '0 && !first_pair_q) begin
						res_valid  = 1'b1;
						res.status = ST_TERM;
						clear      = item.final_byte;
						finished_d = 1'b1;
					end else begin
						first_pair_d    = 1'b0;
						running_value_d = value_new;
						in_pc_delta_d   = 1'b1;
						if (item.final_byte) begin
							// pc delta missing
							res_valid       = 1'b1;
							res.entry_value = value_new;
							clear           = 1'b1;
						end
					end
				end else begin
					res_valid     = 1'b1;
					res.status    = ST_ENTRY;
					res.pc_end    = pc_end;
					res.last      = item.final_byte;
					range_start_d = pc_end;
					in_pc_delta_d = 1'b0;
					clear         = item.final_byte;
				end
			end
		end

		if (clear) begin
			varint_acc_d    = '0;
			group_index_d   = '0;
			in_pc_delta_d   = 1'b0;
			first_pair_d    = 1'b1;
			finished_d      = 1'b0;
			running_value_d = '1;
			range_start_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_scale_q      <= SCALE_RESET;
			varint_acc_q    <= '0;
			group_index_q   <= '0;
			in_pc_delta_q   <= 1'b0;
			first_pair_q    <= 1'b1;
			finished_q      <= 1'b0;
			running_value_q <= '1;
			range_start_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				pc_scale_q <= cfg_wr_data;
			end
			varint_acc_q    <= varint_acc_d;
			group_index_q   <= group_index_d;
			in_pc_delta_q   <= in_pc_delta_d;
			first_pair_q    <= first_pair_d;
			finished_q      <= finished_d;
			running_value_q <= running_value_d;
			range_start_q   <= range_start_d;
		end
	end

endmodule

FILE: hw/rtl/pvtd_out_reg.sv
module pvtd_out_reg
	import pvtd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic valid_q;

	assign advance   = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res <= res;
		end
	end

endmodule

FILE: hw/rtl/pc_value_table_decoder_unit.sv
// pc-to-value table decoder: takes one encoded table byte per beat (s_tlast marks the
// table's last byte) and gives one beat per completed pc delta, terminator, truncated
// varint or entry cut off before its pc delta. One byte is accepted every cycle while
// the output is not stalled; a byte passes an input register, then the varint, zigzag,
// add and pc-scale multiply are done in a single pass against the table state and land
// in the result register. The result register lets the next byte enter while a result
// still waits. pc_scale may only be written between tables while nothing is in flight.
module pc_value_table_decoder_unit
	import pvtd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [SCALE_W-1:0] cfg_wr_data,  // pc_scale
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,      // [7:0] table_byte
	input  logic               s_tlast,      // final_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [95:0]        m_tdata,      // [31:0] pc_start, [63:32] pc_end, [95:64] entry_value
	output logic [1:0]         m_tuser,      // [1:0] status
	output logic               m_tlast       // last
);

	in_item_t in_item;
	in_item_t item_s1;
	logic     advance;
	logic     fire;
	logic     res_valid;
	result_t  res;
	result_t  out_res;

	assign in_item.table_byte = s_tdata;
	assign in_item.final_byte = s_tlast;

	pvtd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	pvtd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.item        (item_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	pvtd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.entry_value, out_res.pc_end, out_res.pc_start};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.last;

endmodule
